>>> rtl/core/ifhg_pkg.sv
// ============================================================================
// ifhg_pkg
// Shared types and constants for the IPv4 fragment header generator.
// ============================================================================
package ifhg_pkg;

    // Fixed header contents
    localparam logic [15:0] VER_IHL_TOS  = 16'h4ffe;
    localparam logic [7:0]  TTL_DEFAULT  = 8'd64;
    localparam logic [15:0] MF_FLAG      = 16'h2000;
    localparam logic [13:0] HDR_BYTES    = 14'd60;
    localparam int          MAX_FRAGS    = 64;
    localparam int          FRAG_CNT_W   = $clog2(MAX_FRAGS);

    // Configuration register indexes
    localparam logic [1:0]  CFG_SRC_ADDR = 2'd0;
    localparam logic [1:0]  CFG_DST_ADDR = 2'd1;
    localparam logic [1:0]  CFG_PROTOCOL = 2'd2;

    // One queued datagram request
    typedef struct packed {
        logic [15:0] len;
        logic [15:0] id;
    } dgram_t;

    // One finished fragment header
    typedef struct packed {
        logic [13:0] fragment_length;
        logic [13:0] ip_total_len;
        logic        more_fragments;
        logic [12:0] offset_units;
        logic [15:0] datagram_id;
        logic [15:0] header_checksum;
        logic        last;
    } frag_hdr_t;

    // Queue status seen by the producer and consumer
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } back_state_t;

endpackage

>>> rtl/core/ifhg_front.sv
// ============================================================================
// ifhg_front
// Accepts datagram requests, assigns the identification value and queues
// every request that carries a nonzero payload.
// ============================================================================
module ifhg_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [15:0]         payload_length,
    input  ifhg_pkg::q_status_t q_status,
    output logic                push,
    output ifhg_pkg::dgram_t    push_data
);

    logic [15:0] packet_counter_reg;
    logic [15:0] packet_counter_next;
    logic        accept;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;

    // An empty datagram still consumes an id but produces no fragments.
    assign push           = accept && (payload_length != 16'd0);
    assign push_data.len  = payload_length;
    assign push_data.id   = packet_counter_reg;

    always_comb
    begin
        packet_counter_next = packet_counter_reg;
        if (accept)
        begin
            packet_counter_next = packet_counter_reg + 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packet_counter_reg <= 16'd0;
        end
        else
        begin
            packet_counter_reg <= packet_counter_next;
        end
    end

endmodule

>>> rtl/core/ifhg_queue.sv
// ============================================================================
// ifhg_queue
// Two-entry request queue between the front and back sections.
// ============================================================================
module ifhg_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ifhg_pkg::dgram_t    push_data,
    input  logic                pop,
    output ifhg_pkg::dgram_t    pop_data,
    output ifhg_pkg::q_status_t status
);

    ifhg_pkg::dgram_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign pop_data     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/core/ifhg_back.sv
// ============================================================================
// ifhg_back
// Walks one queued datagram a fragment per cycle, unless out_ready stalls the
// output, and builds each header, including its checksum, into the output register.
// ============================================================================
module ifhg_back
#(
    parameter int FRAGMENT_PAYLOAD = 1480
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [31:0]          src_addr,
    input  logic [31:0]          dst_addr,
    input  logic [7:0]           protocol,
    input  ifhg_pkg::q_status_t  q_status,
    input  ifhg_pkg::dgram_t     pop_data,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ifhg_pkg::frag_hdr_t  out_hdr
);

    localparam logic [15:0] STEP = 16'(FRAGMENT_PAYLOAD);

    ifhg_pkg::back_state_t state_reg;
    ifhg_pkg::back_state_t state_next;

    logic [15:0] remaining_reg;
    logic [15:0] remaining_next;
    logic [15:0] offset_reg;
    logic [15:0] offset_next;
    logic [15:0] id_reg;
    logic [15:0] id_next;
    logic [ifhg_pkg::FRAG_CNT_W-1:0] frag_cnt_reg;
    logic [ifhg_pkg::FRAG_CNT_W-1:0] frag_cnt_next;
    logic [18:0] base_sum_reg;
    logic [18:0] base_sum_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    ifhg_pkg::frag_hdr_t hdr_reg;
    ifhg_pkg::frag_hdr_t hdr_next;

    logic        slot_free;
    logic        emit;
    logic        more;
    logic [13:0] frag_len;
    logic [13:0] tot_len;
    logic [15:0] flags_off;
    logic [20:0] sum_full;
    logic [16:0] sum_fold1;
    logic [15:0] sum_fold2;
    logic        is_last;

    // Configuration must only be changed by the user while idle, which the block does
    // not enforce, so the registered constant part of the header sum can trail it.
    assign base_sum_next = 19'(ifhg_pkg::VER_IHL_TOS)
                         + 19'({ifhg_pkg::TTL_DEFAULT, protocol})
                         + 19'(src_addr[31:16]) + 19'(src_addr[15:0])
                         + 19'(dst_addr[31:16]) + 19'(dst_addr[15:0]);

    assign slot_free = !out_valid_reg || out_ready;
    assign emit      = (state_reg == ifhg_pkg::ST_RUN) && slot_free;

    assign more      = remaining_reg > STEP;
    assign frag_len  = more ? STEP[13:0] : remaining_reg[13:0];
    assign tot_len   = frag_len + ifhg_pkg::HDR_BYTES;
    assign flags_off = (more ? ifhg_pkg::MF_FLAG : 16'd0) | {3'd0, offset_reg[15:3]};
    assign is_last   = !more
                     || (frag_cnt_reg == ifhg_pkg::FRAG_CNT_W'(ifhg_pkg::MAX_FRAGS - 1));

    // Two end-around carry folds bring the sum back to 16 bits.
    assign sum_full  = 21'(base_sum_reg) + 21'({2'd0, tot_len}) + 21'(id_reg)
                     + 21'(flags_off);
    assign sum_fold1 = 17'(sum_full[15:0]) + 17'(sum_full[20:16]);
    assign sum_fold2 = sum_fold1[15:0] + 16'(sum_fold1[16]);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ifhg_pkg::ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    state_next = ifhg_pkg::ST_RUN;
                end
            end
            ifhg_pkg::ST_RUN:
            begin
                if (emit && is_last)
                begin
                    state_next = ifhg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ifhg_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath
    always_comb
    begin
        pop            = 1'b0;
        remaining_next = remaining_reg;
        offset_next    = offset_reg;
        id_next        = id_reg;
        frag_cnt_next  = frag_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        hdr_next       = hdr_reg;
        case (state_reg)
            ifhg_pkg::ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop            = 1'b1;
                    remaining_next = pop_data.len;
                    offset_next    = 16'd0;
                    id_next        = pop_data.id;
                    frag_cnt_next  = '0;
                end
            end
            ifhg_pkg::ST_RUN:
            begin
                if (emit)
                begin
                    remaining_next           = remaining_reg - 16'(frag_len);
                    offset_next              = offset_reg + 16'(frag_len);
                    frag_cnt_next            = frag_cnt_reg + ifhg_pkg::FRAG_CNT_W'(1);
                    out_valid_next           = 1'b1;
                    hdr_next.fragment_length = frag_len;
                    hdr_next.ip_total_len    = tot_len;
                    hdr_next.more_fragments  = more;
                    hdr_next.offset_units    = offset_reg[15:3];
                    hdr_next.datagram_id     = id_reg;
                    hdr_next.header_checksum = ~sum_fold2;
                    hdr_next.last            = is_last;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_hdr   = hdr_reg;

    always_ff @(posedge clk)
    begin
        remaining_reg <= remaining_next;
        offset_reg    <= offset_next;
        id_reg        <= id_next;
        frag_cnt_reg  <= frag_cnt_next;
        base_sum_reg  <= base_sum_next;
        hdr_reg       <= hdr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ifhg_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> rtl/core/ipv4_fragment_header_generator.sv
// Path: an accepted request is queued, loaded into the fragment walker, then built
// into the output header register. Throughput: one fragment header per cycle while
// the output is not stalled by out_ready, plus an idle state per datagram to load it
// from the request queue into the fragment walker; empty requests are never queued.
// Reset: asynchronous, active low; clears the id counter, the queue, the walker
// state, the output valid flag and the configuration registers.
// ============================================================================
// ipv4_fragment_header_generator
// Splits each datagram request into fragments and emits the IPv4 header
// fields and checksum for every fragment.
// ============================================================================
module ipv4_fragment_header_generator
#(
    parameter int FRAGMENT_PAYLOAD = 1480
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] payload_length,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [13:0] fragment_length,
    output logic [13:0] ip_total_len,
    output logic        more_fragments,
    output logic [12:0] offset_units,
    output logic [15:0] datagram_id,
    output logic [15:0] header_checksum,
    output logic        last
);

    logic [31:0] src_addr_reg;
    logic [31:0] dst_addr_reg;
    logic [7:0]  protocol_reg;

    ifhg_pkg::q_status_t q_status;
    ifhg_pkg::dgram_t    push_data;
    ifhg_pkg::dgram_t    pop_data;
    ifhg_pkg::frag_hdr_t out_hdr;
    logic                push;
    logic                pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_addr_reg <= 32'd0;
            dst_addr_reg <= 32'd0;
            protocol_reg <= 8'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ifhg_pkg::CFG_SRC_ADDR: src_addr_reg <= cfg_data;
                ifhg_pkg::CFG_DST_ADDR: dst_addr_reg <= cfg_data;
                ifhg_pkg::CFG_PROTOCOL: protocol_reg <= cfg_data[7:0];
                default:                protocol_reg <= protocol_reg;
            endcase
        end
    end

    ifhg_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .payload_length (payload_length),
        .q_status       (q_status),
        .push           (push),
        .push_data      (push_data)
    );

    ifhg_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    ifhg_back #(
        .FRAGMENT_PAYLOAD (FRAGMENT_PAYLOAD)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_addr  (src_addr_reg),
        .dst_addr  (dst_addr_reg),
        .protocol  (protocol_reg),
        .q_status  (q_status),
        .pop_data  (pop_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_hdr   (out_hdr)
    );

    assign fragment_length = out_hdr.fragment_length;
    assign ip_total_len    = out_hdr.ip_total_len;
    assign more_fragments  = out_hdr.more_fragments;
    assign offset_units    = out_hdr.offset_units;
    assign datagram_id     = out_hdr.datagram_id;
    assign header_checksum = out_hdr.header_checksum;
    assign last            = out_hdr.last;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_status.full && !pop))
        else $error("request queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("request queue read while empty");

    a_nonzero_frag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (fragment_length != 14'd0))
        else $error("empty fragment emitted");

    a_total_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (ip_total_len == fragment_length + ifhg_pkg::HDR_BYTES))
        else $error("total length does not match fragment length");

    a_last_frag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !more_fragments) |-> last)
        else $error("final fragment not marked last");

endmodule

>>> test/ipv4_fragment_header_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// ipv4_fragment_header_checker
// Watches the request, result and register ports of the fragment header
// generator, predicts every fragment header from its own copy of the
// addresses, protocol and id counter, and compares results in order.
// ============================================================================
module ipv4_fragment_header_checker
#(
    parameter int FRAGMENT_PAYLOAD = 1480
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [15:0] payload_length,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [13:0] fragment_length,
    input  logic [13:0] ip_total_len,
    input  logic        more_fragments,
    input  logic [12:0] offset_units,
    input  logic [15:0] datagram_id,
    input  logic [15:0] header_checksum,
    input  logic        last,
    output int          fail_count,
    output int          outstanding
);

    logic [31:0]         src_addr  = '0;
    logic [31:0]         dst_addr  = '0;
    logic [7:0]          proto     = '0;
    logic [15:0]         next_id   = '0;
    ifhg_pkg::frag_hdr_t expected_headers[$];

    function automatic logic [15:0] header_checksum_of(input logic [15:0] tot,
                                                       input logic [15:0] id,
                                                       input logic [15:0] flags_off);
        logic [31:0] acc;
        acc = {16'h0, ifhg_pkg::VER_IHL_TOS} + {16'h0, tot} + {16'h0, id}
            + {16'h0, flags_off}
            + {16'h0, ifhg_pkg::TTL_DEFAULT, proto}
            + {16'h0, src_addr[31:16]} + {16'h0, src_addr[15:0]}
            + {16'h0, dst_addr[31:16]} + {16'h0, dst_addr[15:0]};
        while (acc[31:16] != 16'h0)
            acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
        return ~acc[15:0];
    endfunction

    // Splits one datagram into its fragment headers; the id advances even for
    // an empty datagram.
    task automatic queue_fragments(input logic [15:0] len);
        int                  remaining;
        int                  offset;
        int                  frag;
        int                  n;
        logic                more;
        logic [15:0]         tot;
        logic [15:0]         flags_off;
        ifhg_pkg::frag_hdr_t h;
        remaining = len;
        offset    = 0;
        n         = 0;
        while (remaining > 0 && n < ifhg_pkg::MAX_FRAGS)
        begin
            more = remaining > FRAGMENT_PAYLOAD;
            frag = more ? FRAGMENT_PAYLOAD : remaining;
            tot  = 16'(frag) + 16'(ifhg_pkg::HDR_BYTES);
            h.fragment_length = 14'(frag);
            h.ip_total_len    = tot[13:0];
            h.more_fragments  = more;
            h.offset_units    = 13'(offset >> 3);
            h.datagram_id     = next_id;
            flags_off         = (more ? ifhg_pkg::MF_FLAG : 16'h0)
                              | {3'b000, h.offset_units};
            h.header_checksum = header_checksum_of(tot, next_id, flags_off);
            h.last            = !more || n == ifhg_pkg::MAX_FRAGS - 1;
            expected_headers.push_back(h);
            remaining -= frag;
            offset    += frag;
            n++;
        end
        next_id = next_id + 16'd1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        ifhg_pkg::frag_hdr_t got;
        ifhg_pkg::frag_hdr_t want;
        if (!rst_n)
        begin
            src_addr = '0;
            dst_addr = '0;
            proto    = '0;
            next_id  = '0;
            expected_headers.delete();
            outstanding = 0;
            fail_count  = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ifhg_pkg::CFG_SRC_ADDR: src_addr = cfg_data;
                    ifhg_pkg::CFG_DST_ADDR: dst_addr = cfg_data;
                    ifhg_pkg::CFG_PROTOCOL: proto    = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                queue_fragments(payload_length);
            if (out_valid && out_ready)
            begin
                got = {fragment_length, ip_total_len, more_fragments, offset_units,
                       datagram_id, header_checksum, last};
                if (expected_headers.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("extra: len %0d tot %0d mf %0b off %0d id %h sum %h last %0b",
                                 got.fragment_length, got.ip_total_len, got.more_fragments,
                                 got.offset_units, got.datagram_id, got.header_checksum,
                                 got.last);
                    fail_count++;
                end
                else
                begin
                    want = expected_headers.pop_front();
                    if (got != want)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("exp: len %0d tot %0d mf %0b off %0d id %h sum %h last %0b",
                                     want.fragment_length, want.ip_total_len,
                                     want.more_fragments, want.offset_units,
                                     want.datagram_id, want.header_checksum, want.last);
                            $display("got: len %0d tot %0d mf %0b off %0d id %h sum %h last %0b",
                                     got.fragment_length, got.ip_total_len,
                                     got.more_fragments, got.offset_units,
                                     got.datagram_id, got.header_checksum, got.last);
                        end
                        fail_count++;
                    end
                end
            end
            outstanding = expected_headers.size();
        end
    end

endmodule

>>> test/ipv4_fragment_header_generator_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// ipv4_fragment_header_generator_tb
// Drives length requests and register writes into the fragment header
// generator: a directed set of edge lengths, then random lengths under four
// idling patterns and several address settings. A checker beside the block
// scores every header.
// ============================================================================
module ipv4_fragment_header_generator_tb;

    localparam int         FRAG_BYTES       = 1480;
    localparam int         RESET_CYCLES     = 6;
    localparam int         QUIET_LIMIT      = 4000;
    localparam int         DRAIN_CYCLES     = 40;
    localparam int         RANDOM_PER_PHASE = 85;
    localparam logic [1:0] CFG_UNMAPPED     = 2'd3;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        cfg_we         = 1'b0;
    logic [1:0]  cfg_index      = '0;
    logic [31:0] cfg_data       = '0;
    logic        in_valid       = 1'b0;
    logic [15:0] payload_length = '0;
    logic        out_ready      = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic [13:0] fragment_length;
    logic [13:0] ip_total_len;
    logic        more_fragments;
    logic [12:0] offset_units;
    logic [15:0] datagram_id;
    logic [15:0] header_checksum;
    logic        last;

    int fail_count;
    int outstanding;
    int stall_pct    = 0;
    int quiet_cycles = 0;
    int sent_count   = 0;

    int sender_idle[4]    = '{0, 71, 0, 11};
    int receiver_stall[4] = '{0, 0, 71, 11};

    logic [15:0] edge_lengths[20] = '{
        16'd0, 16'd1, 16'd7, 16'd8, 16'd9, 16'd1024, 16'd1479, 16'd1480, 16'd1481,
        16'd2959, 16'd2960, 16'd2961, 16'd8192, 16'd65120, 16'd65121, 16'd65534,
        16'd65535, 16'h5555, 16'haaaa, 16'd0
    };

    ipv4_fragment_header_generator #(
        .FRAGMENT_PAYLOAD(FRAG_BYTES)
    ) DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .payload_length  (payload_length),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .fragment_length (fragment_length),
        .ip_total_len    (ip_total_len),
        .more_fragments  (more_fragments),
        .offset_units    (offset_units),
        .datagram_id     (datagram_id),
        .header_checksum (header_checksum),
        .last            (last)
    );

    ipv4_fragment_header_checker #(
        .FRAGMENT_PAYLOAD(FRAG_BYTES)
    ) header_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .payload_length  (payload_length),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .fragment_length (fragment_length),
        .ip_total_len    (ip_total_len),
        .more_fragments  (more_fragments),
        .offset_units    (offset_units),
        .datagram_id     (datagram_id),
        .header_checksum (header_checksum),
        .last            (last),
        .fail_count      (fail_count),
        .outstanding     (outstanding)
    );

    always #2 clk = ~clk;

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    // The watchdog only counts cycles in which no request and no header moves.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Entered and left at a falling edge; valid is only dropped while idling.
    task automatic send_length(input logic [15:0] len, input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        payload_length <= len;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // The write to the unmapped index comes last so a bad decode would
    // clobber one of the real registers.
    task automatic load_addresses(input logic [31:0] src, input logic [31:0] dst,
                                  input logic [7:0] proto);
        wait_idle();
        write_reg(ifhg_pkg::CFG_SRC_ADDR, src);
        write_reg(ifhg_pkg::CFG_DST_ADDR, dst);
        write_reg(ifhg_pkg::CFG_PROTOCOL, {24'($urandom()), proto});
        write_reg(CFG_UNMAPPED, $urandom());
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [15:0] pick_length();
        int pick;
        int v;
        pick = $urandom_range(99);
        if (pick < 25)
            v = $urandom_range(3 * FRAG_BYTES, 1);
        else if (pick < 45)
            v = $urandom_range(65535);
        else if (pick < 60)
            v = $urandom_range(44, 1) * FRAG_BYTES + $urandom_range(2) - 1;
        else if (pick < 70)
            v = $urandom_range(65535, 65000);
        else if (pick < 78)
            v = 0;
        else if (pick < 90)
            v = $urandom_range(16, 1);
        else
            v = $urandom();
        return v[15:0];
    endfunction

    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Edge lengths with the registers still at their reset values.
        foreach (edge_lengths[i])
            send_length(edge_lengths[i], 0);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: load_addresses(32'hffff_ffff, 32'hffff_ffff, 8'hff);
                1: load_addresses($urandom(), $urandom(), 8'($urandom_range(255)));
                2: load_addresses(32'h0, 32'hffff_ffff, 8'($urandom_range(255)));
                default: load_addresses($urandom(), $urandom(), 8'($urandom_range(255)));
            endcase
            stall_pct <= receiver_stall[phase];
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                send_length(pick_length(), sender_idle[phase]);
        end

        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
